// ----- src/pnf_pkg.sv -----
// ----------------------------------------------------------------------------
// pnf_pkg
// Shared constants, types and coefficient tables for the pink noise filter.
// ----------------------------------------------------------------------------
`default_nettype none

package pnf_pkg;

	// fixed-point formats
	localparam int INPUT_BITS_DEF = 16;
	localparam int COEF_FRAC      = 24;
	localparam int GAIN_FRAC      = 12;
	localparam int OUT_FRAC       = 23;
	localparam int OUT_SHIFT      = COEF_FRAC + GAIN_FRAC - OUT_FRAC;

	// datapath widths
	localparam int DIGIT_W     = 4;
	localparam int COEF_W      = 25;
	localparam int PROD_W      = COEF_W + DIGIT_W + 1;
	localparam int STATE_W     = 32;
	localparam int RES_W       = STATE_W + 2;
	localparam int ACC_W       = 31;
	localparam int PINK_W      = 35;
	localparam int OPA_W       = 36;
	localparam int GAIN_W      = 16;
	localparam int OUT_W       = 24;
	localparam int NUM_TAPS    = 7;
	localparam int SECT_IDX_W  = 3;
	localparam int PASS_W      = 4;
	localparam int DIGIT_CNT_W = 4;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic [PASS_W-1:0]        pass_t;
	typedef logic [DIGIT_CNT_W-1:0]   digit_cnt_t;

	// pass codes: sections 0..5 come first
	localparam pass_t PASS_FIRST  = 4'd0;
	localparam pass_t PASS_DIRECT = 4'd6;
	localparam pass_t PASS_TAP    = 4'd7;
	localparam pass_t PASS_GAIN   = 4'd8;

	localparam logic [SECT_IDX_W-1:0] TAP_IDX = SECT_IDX_W'(NUM_TAPS - 1);

	// last digit index of each pass
	localparam digit_cnt_t SECT_LAST = DIGIT_CNT_W'(STATE_W / DIGIT_W - 1);
	localparam digit_cnt_t GAIN_LAST = DIGIT_CNT_W'(OPA_W / DIGIT_W - 1);

	// rounding preloads (add half before floor)
	localparam logic signed [ACC_W-1:0] ROUND_SECT = ACC_W'(1) << (COEF_FRAC - 1);
	localparam logic signed [ACC_W-1:0] ROUND_OUT  = ACC_W'(1) << (OUT_SHIFT - 1);

	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

	localparam logic signed [STATE_W-1:0] STATE_MAX = {1'b0, {(STATE_W-1){1'b1}}};
	localparam logic signed [STATE_W-1:0] STATE_MIN = {1'b1, {(STATE_W-1){1'b0}}};
	localparam logic signed [OUT_W-1:0]   OUT_MAX   = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0]   OUT_MIN   = {1'b1, {(OUT_W-1){1'b0}}};

	// feedback coefficient of each pass, zero where the pass has no state term
	function automatic coef_t pole_coef(input pass_t p);
		coef_t c;
		unique case (p)
			4'd0:    c = 25'sd16758090;
			4'd1:    c = 25'sd16665144;
			4'd2:    c = 25'sd16257122;
			4'd3:    c = 25'sd14537458;
			4'd4:    c = 25'sd9227469;
			4'd5:    c = -25'sd12777528;
			default: c = '0;
		endcase
		return c;
	endfunction

	// coefficient on the white sample for each pass
	function automatic coef_t feed_coef(input pass_t p);
		coef_t c;
		unique case (p)
			4'd0:        c = 25'sd931436;
			4'd1:        c = 25'sd1259565;
			4'd2:        c = 25'sd2581208;
			4'd3:        c = 25'sd5209084;
			4'd4:        c = 25'sd8941454;
			4'd5:        c = -25'sd283501;
			PASS_DIRECT: c = 25'sd8995943;
			PASS_TAP:    c = 25'sd1944918;
			default:     c = '0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- src/pink_noise_filter_top.sv -----
// Each accepted white word runs nine passes of a 4-bit digit-serial multiply-add
// (eight of 8 digits, the output gain pass of 9), then the output load and the return to idle.
// in_stall is low only while idle; a stalled output word holds the finish, otherwise
// a finished result waits in the output register while the next word is taken.
// Reset: section states clear to zero, output gain returns to 1.0.
// ----------------------------------------------------------------------------
// pink_noise_filter_top
// White-to-pink noise shaping filter: six one-pole sections, a delayed tap
// and a direct path, scaled by a programmable gain and saturated to 24 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module pink_noise_filter_top
	import pnf_pkg::*;
#(
	parameter int INPUT_BITS = INPUT_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// white noise input
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic signed [INPUT_BITS-1:0]   white_sample,
	// pink noise output
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic signed [OUT_W-1:0]             pink_sample,
	output logic                                clipped,
	// gain register write
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [GAIN_W-1:0]              cfg_data
);

	localparam int WHITE_SHIFT = COEF_FRAC + 1 - INPUT_BITS;

	typedef enum logic [1:0] {IDLE_ST, RUN_ST, DONE_ST} fsm_t;

	fsm_t                        fsm_q;
	pass_t                       pass_q;
	digit_cnt_t                  digit_q;
	logic [GAIN_W-1:0]           gain_q;
	logic signed [STATE_W-1:0]   section_q [NUM_TAPS];
	logic                        wb_valid_q;
	pass_t                       wb_pass_q;
	logic signed [RES_W-1:0]     res_q;
	logic signed [STATE_W-1:0]   white_q;
	logic signed [OPA_W-1:0]     opa_q;
	logic signed [STATE_W-1:0]   opb_q;
	logic signed [ACC_W-1:0]     w_q;
	logic [OPA_W-1:0]            l_q;
	logic signed [PINK_W-1:0]    pink_q;

	logic                        accept;
	logic                        out_free;
	logic signed [STATE_W-1:0]   white_ext;
	digit_cnt_t                  last_digit;
	logic                        digit_end;
	logic                        last_sig;
	coef_t                       a_sel;
	coef_t                       b_sel;
	logic signed [DIGIT_W:0]     dig_a;
	logic signed [DIGIT_W:0]     dig_b;
	logic signed [PROD_W-1:0]    prod_a;
	logic signed [PROD_W-1:0]    prod_b;
	logic signed [ACC_W-1:0]     t_sum;
	pass_t                       pass_nx;
	logic signed [OPA_W-1:0]     opa_load;
	logic signed [STATE_W-1:0]   opb_load;
	logic signed [ACC_W-1:0]     w_load;
	logic signed [STATE_W-1:0]   sat_res;
	logic                        wb_state_en;
	logic [SECT_IDX_W-1:0]       wb_idx;
	logic                        fin_fits;
	logic signed [OUT_W-1:0]     fin_val;
	logic                        fin_clip;

	// handshake
	assign in_stall  = (fsm_q != IDLE_ST);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid || !out_stall;
	assign cfg_ready = 1'b1;

	// white sample widened to Q.24 in the state format
	assign white_ext = STATE_W'(white_sample) <<< WHITE_SHIFT;

	// digit sequencing
	assign last_digit = (pass_q == PASS_GAIN) ? GAIN_LAST : SECT_LAST;
	assign digit_end  = (fsm_q == RUN_ST) && (digit_q == last_digit);
	assign last_sig   = (digit_q == last_digit);

	// digit-serial multiply-add: top digit carries the sign weight
	always_comb begin
		a_sel = (pass_q == PASS_GAIN) ? coef_t'({1'b0, gain_q}) : pole_coef(pass_q);
		b_sel = feed_coef(pass_q);
		dig_a = last_sig ? {opa_q[DIGIT_W-1], opa_q[DIGIT_W-1:0]}
		                 : {1'b0, opa_q[DIGIT_W-1:0]};
		dig_b = last_sig ? {opb_q[DIGIT_W-1], opb_q[DIGIT_W-1:0]}
		                 : {1'b0, opb_q[DIGIT_W-1:0]};
		prod_a = a_sel * dig_a;
		prod_b = b_sel * dig_b;
		t_sum  = w_q + ACC_W'(prod_a) + ACC_W'(prod_b);
	end

	// operands and rounding preload for the following pass
	always_comb begin
		pass_nx = pass_q + 1'b1;
		if (pass_nx < PASS_DIRECT) begin
			opa_load = OPA_W'(section_q[pass_nx[SECT_IDX_W-1:0]]);
		end else if (pass_nx == PASS_GAIN) begin
			opa_load = OPA_W'(pink_q);
		end else begin
			opa_load = '0;
		end
		opb_load = (pass_nx == PASS_GAIN) ? '0 : white_q;
		w_load   = (pass_nx == PASS_GAIN) ? ROUND_OUT : ROUND_SECT;
	end

	// write-back of a finished pass: saturate to the state range
	always_comb begin
		if ((&res_q[RES_W-1:STATE_W-1]) || !(|res_q[RES_W-1:STATE_W-1])) begin
			sat_res = res_q[STATE_W-1:0];
		end else begin
			sat_res = res_q[RES_W-1] ? STATE_MIN : STATE_MAX;
		end
		wb_state_en = wb_valid_q && (wb_pass_q != PASS_DIRECT);
		wb_idx      = (wb_pass_q == PASS_TAP) ? TAP_IDX : wb_pass_q[SECT_IDX_W-1:0];
	end

	// final scaling: window holds the bits above the 24-bit result
	always_comb begin
		fin_fits = (&w_q) || !(|w_q);
		if (fin_fits) begin
			fin_val  = {w_q[0], l_q[OPA_W-1 -: OUT_W-1]};
			fin_clip = 1'b0;
		end else begin
			fin_val  = w_q[ACC_W-1] ? OUT_MIN : OUT_MAX;
			fin_clip = 1'b1;
		end
	end

	// control state machine and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q       <= IDLE_ST;
			pass_q      <= PASS_FIRST;
			digit_q     <= '0;
			gain_q      <= GAIN_RESET;
			wb_valid_q  <= 1'b0;
			wb_pass_q   <= PASS_FIRST;
			out_valid   <= 1'b0;
			pink_sample <= '0;
			clipped     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				gain_q <= cfg_data;
			end
			// output word loads when free, holds while stalled
			out_valid  <= ((fsm_q == DONE_ST) && out_free) || (out_valid && out_stall);
			wb_valid_q <= digit_end && (pass_q != PASS_GAIN);
			unique case (fsm_q)
				IDLE_ST: begin
					if (accept) begin
						fsm_q   <= RUN_ST;
						pass_q  <= PASS_FIRST;
						digit_q <= '0;
					end
				end
				RUN_ST: begin
					if (digit_end) begin
						digit_q <= '0;
						if (pass_q == PASS_GAIN) begin
							fsm_q <= DONE_ST;
						end else begin
							pass_q     <= pass_nx;
							wb_pass_q  <= pass_q;
						end
					end else begin
						digit_q <= digit_q + 1'b1;
					end
				end
				DONE_ST: begin
					if (out_free) begin
						pink_sample <= fin_val;
						clipped     <= fin_clip;
						fsm_q       <= IDLE_ST;
					end
				end
				default: fsm_q <= IDLE_ST;
			endcase
		end
	end

	// section and tap state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TAPS; i++) begin
				section_q[i] <= '0;
			end
		end else if (wb_state_en) begin
			section_q[wb_idx] <= sat_res;
		end
	end

	// digit-serial datapath shift registers
	always_ff @(posedge clk) begin
		if (accept) begin
			white_q <= white_ext;
			opa_q   <= OPA_W'(section_q[0]);
			opb_q   <= white_ext;
			w_q     <= ROUND_SECT;
			pink_q  <= PINK_W'(section_q[TAP_IDX]);
		end else if (fsm_q == RUN_ST) begin
			// end of a filter pass: capture its result, start the next one
			if (digit_end && (pass_q != PASS_GAIN)) begin
				res_q <= {t_sum[RES_W-DIGIT_W-1:0], l_q[OPA_W-1 -: DIGIT_W]};
				opa_q <= opa_load;
				opb_q <= opb_load;
				w_q   <= w_load;
			end else begin
				opa_q <= opa_q >>> DIGIT_W;
				opb_q <= opb_q >>> DIGIT_W;
				w_q   <= t_sum >>> DIGIT_W;
			end
			l_q <= {t_sum[DIGIT_W-1:0], l_q[OPA_W-1:DIGIT_W]};
		end
		// pink sum collects the sections and the direct path
		if (wb_valid_q && (wb_pass_q != PASS_TAP)) begin
			pink_q <= pink_q + PINK_W'(sat_res);
		end
	end

`ifndef SYNTHESIS
	// an accepted word starts the first pass at its first digit
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (fsm_q == RUN_ST) && (pass_q == PASS_FIRST) && (digit_q == '0))
		else $error("pass sequence did not start cleanly");

	// write-back only happens while passes are running
	a_wb_run: assert property (@(posedge clk) disable iff (!arst_n)
		wb_valid_q |-> (fsm_q == RUN_ST) && (wb_pass_q != PASS_GAIN))
		else $error("write-back outside the pass sequence");

	// digit counter stays inside the current pass
	a_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(fsm_q == RUN_ST) |-> (digit_q <= last_digit))
		else $error("digit counter overran its pass");

	// a clipped word carries a rail value
	a_clip: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && clipped) |-> (pink_sample == OUT_MAX) || (pink_sample == OUT_MIN))
		else $error("clipped word is not at a rail");
`endif

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pink_noise_filter_top. A bit-exact model of the six
// one-pole sections, the delayed tap, the direct path and the gain stage
// predicts each pink word. Stimulus runs the sample extremes, saturation at
// both rails, zero and full-scale gain, then random samples over several gain
// settings with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import pnf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WHITE_W = INPUT_BITS_DEF;
	localparam logic signed [WHITE_W-1:0] WHITE_MAX = {1'b0, {(WHITE_W-1){1'b1}}};
	localparam logic signed [WHITE_W-1:0] WHITE_MIN = {1'b1, {(WHITE_W-1){1'b0}}};
	localparam int SETTLE_CYCLES = 80;
	localparam int MAX_GAP = 14;

	typedef struct packed {
		logic signed [OUT_W-1:0] pink;
		logic                    clip;
	} pink_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [WHITE_W-1:0] white_sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [OUT_W-1:0] pink_sample;
	logic clipped;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [GAIN_W-1:0] cfg_data = '0;

	// filter model state and gain
	logic signed [STATE_W-1:0] sect_q [NUM_TAPS];
	logic [GAIN_W-1:0] gain_q;

	pink_word_t pink_due [$];
	int mismatch_count = 0;
	bit no_idle = 1'b0;

	pink_noise_filter_top #(.INPUT_BITS(WHITE_W)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.white_sample (white_sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pink_sample  (pink_sample),
		.clipped      (clipped),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run limit
	initial begin
		#6ms;
		$display("[pink_noise_filter_top] ERROR");
		$finish;
	end

	// section feedback coefficients, Q.24
	function automatic longint pole_k(input int i);
		case (i)
			0:       return 64'sd16758090;
			1:       return 64'sd16665144;
			2:       return 64'sd16257122;
			3:       return 64'sd14537458;
			4:       return 64'sd9227469;
			default: return -64'sd12777528;
		endcase
	endfunction

	// section feed coefficients, Q.24
	function automatic longint in_k(input int i);
		case (i)
			0:       return 64'sd931436;
			1:       return 64'sd1259565;
			2:       return 64'sd2581208;
			3:       return 64'sd5209084;
			4:       return 64'sd8941454;
			default: return -64'sd283501;
		endcase
	endfunction

	// add half, then floor
	function automatic longint round_down(input longint v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [STATE_W-1:0] clamp_state(input longint v);
		if (v > longint'(STATE_MAX))
			return STATE_MAX;
		if (v < longint'(STATE_MIN))
			return STATE_MIN;
		return v[STATE_W-1:0];
	endfunction

	// one filter step: updates the model state, returns the pink word
	function automatic pink_word_t shape_white(input logic signed [WHITE_W-1:0] w);
		longint white;
		longint pink;
		longint scaled;
		pink_word_t r;
		white = longint'(w) <<< (COEF_FRAC + 1 - WHITE_W);
		for (int i = 0; i < NUM_TAPS - 1; i++) begin
			sect_q[i] = clamp_state(round_down(pole_k(i) * longint'(sect_q[i])
				+ in_k(i) * white, COEF_FRAC));
		end
		pink = round_down(64'sd8995943 * white, COEF_FRAC);
		for (int i = 0; i < NUM_TAPS; i++)
			pink += longint'(sect_q[i]);
		sect_q[NUM_TAPS-1] = clamp_state(round_down(64'sd1944918 * white, COEF_FRAC));
		scaled = round_down(pink * longint'(gain_q), OUT_SHIFT);
		r.clip = 1'b0;
		if (scaled > longint'(OUT_MAX)) begin
			scaled = longint'(OUT_MAX);
			r.clip = 1'b1;
		end else if (scaled < longint'(OUT_MIN)) begin
			scaled = longint'(OUT_MIN);
			r.clip = 1'b1;
		end
		r.pink = scaled[OUT_W-1:0];
		return r;
	endfunction

	// send one white word; returns at a falling edge with in_valid still high
	task automatic send_white(input logic signed [WHITE_W-1:0] v);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		repeat (gap) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		white_sample <= v;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		pink_due.push_back(shape_white(v));
		@(negedge clk);
	endtask

	// let every pink word out, then let the block go quiet
	task automatic drain_block();
		in_valid <= 1'b0;
		while (pink_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// gain register write, block idle
	task automatic write_gain(input logic [GAIN_W-1:0] g);
		cfg_valid <= 1'b1;
		cfg_data <= g;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		gain_q = g;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// output side: random stall, then check each word against the oldest prediction
	always begin : pink_check
		int hold;
		pink_word_t want;
		wait (arst_n === 1'b1);
		hold = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		repeat (hold) begin
			@(negedge clk);
			out_stall <= 1'b1;
		end
		@(negedge clk);
		out_stall <= 1'b0;
		do
			@(posedge clk);
		while (out_valid !== 1'b1);
		if (pink_due.size() == 0) begin
			$error("unexpected pink word: pink_sample %0d clipped %0b", pink_sample, clipped);
			mismatch_count++;
		end else begin
			want = pink_due.pop_front();
			if (pink_sample !== want.pink) begin
				$error("pink_sample expected %0d actual %0d", want.pink, pink_sample);
				mismatch_count++;
			end
			if (clipped !== want.clip) begin
				$error("clipped expected %0b actual %0b", want.clip, clipped);
				mismatch_count++;
			end
		end
	end

	// sample extremes under the reset gain of 1.0
	task automatic check_reset_gain();
		send_white('0);
		send_white(WHITE_MAX);
		send_white(WHITE_MIN);
		send_white(WHITE_W'(1));
		send_white(WHITE_W'(-1));
		send_white(WHITE_MAX);
	endtask

	// full-scale gain with dc runs to clip at both rails, then zero gain
	task automatic check_saturation();
		drain_block();
		write_gain('1);
		repeat (7) send_white(WHITE_MAX);
		repeat (7) send_white(WHITE_MIN);
		drain_block();
		write_gain('0);
		repeat (3) send_white(WHITE_MAX);
	endtask

	// one gain setting with random words and dc bursts
	task automatic run_gain_phase(input logic [GAIN_W-1:0] g, input int count,
		input bit calm);
		int n;
		int burst;
		logic signed [WHITE_W-1:0] level;
		drain_block();
		write_gain(g);
		no_idle = calm;
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 9) == 0) begin
				burst = $urandom_range(4, 16);
				level = $urandom_range(0, 1) ? WHITE_MAX : WHITE_MIN;
				repeat (burst) send_white(level);
				n += burst;
			end else begin
				send_white(WHITE_W'($urandom));
				n++;
			end
		end
		no_idle = 1'b0;
	endtask

	// random words across several gains, extremes among them
	task automatic check_random_gains();
		run_gain_phase(GAIN_RESET, 90, 1'b0);
		run_gain_phase('1, 90, 1'b0);
		run_gain_phase('0, 90, 1'b1);
		run_gain_phase(GAIN_W'($urandom), 90, 1'b0);
		run_gain_phase(GAIN_W'($urandom), 90, 1'b0);
		run_gain_phase(16'd1, 90, 1'b0);
		run_gain_phase(16'd2048, 90, 1'b1);
		run_gain_phase(16'd8192, 90, 1'b0);
		run_gain_phase(GAIN_W'($urandom), 90, 1'b0);
	endtask

	// main sequence
	initial begin
		for (int i = 0; i < NUM_TAPS; i++)
			sect_q[i] = '0;
		gain_q = GAIN_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		check_reset_gain();
		check_saturation();
		check_random_gains();
		in_valid <= 1'b0;
		while (pink_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pink_due.size() == 0) begin
			$display("[pink_noise_filter_top] OK");
		end else begin
			$display("[pink_noise_filter_top] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- pink_noise_filter_top.f -----
src/pnf_pkg.sv
src/pink_noise_filter_top.sv
tb/testbench.sv
